// ===== hdl/pidvdt_pkg.sv =====
// ============================================================================
// pidvdt_pkg
// Shared widths, constants, types and codes for the variable-step PID core.
// ============================================================================
`default_nettype none

package pidvdt_pkg;

    // Field and datapath widths
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DT_W      = 24;
    localparam int unsigned ACC_W     = 48;
    localparam int unsigned MUL_AW    = 48;
    localparam int unsigned MUL_BW    = 32;
    localparam int unsigned MUL_PW    = MUL_AW + MUL_BW;
    localparam int unsigned DIV_NW    = 56;
    localparam int unsigned DIV_DW    = 24;
    localparam int unsigned TERM_W    = MUL_PW - 15;
    localparam int unsigned SUM_W     = TERM_W + 1;
    localparam int unsigned NUMK_W    = 43;
    localparam int unsigned CFG_IDX_W = 3;

    // Arithmetic constants (Q16.16 where signed)
    localparam logic signed [DATA_W-1:0] SP_LIMIT  = 32'sd655360;
    localparam logic signed [DATA_W-1:0] DEADBAND  = 32'sd6553;
    localparam logic [DIV_DW-1:0]        US_PER_MS = 24'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP  = 3'd0,
        CFG_INTEG = 3'd1,
        CFG_DERIV = 3'd2,
        CFG_UPPER = 3'd3,
        CFG_LOWER = 3'd4
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL1,
        S_DIV1,
        S_ACC,
        S_LAUNCH2,
        S_DIV2,
        S_MUL3,
        S_SUM,
        S_SAT,
        S_CLAMP,
        S_EMIT
    } t_state;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

// ===== hdl/pid_controller_variable_dt_core.sv =====
// ============================================================================
// pid_controller_variable_dt_core
// PID controller in signed Q16.16 with a per-item time step in microseconds.
// ============================================================================
// The sequencer takes one item at a time through its states; with zero elapsed
// time (drive 0, state kept) it goes from idle straight to the emit state. The
// run time is set by one shared bit-serial divider (two passes: error*dt/1000
// and the derivative quotient) and one shared bit-serial multiplier (four
// passes), with the proportional and integral products overlapped with the
// divides. The emit state waits while the output register holds a result
// that is not taken. The next item is accepted as soon as the sequencer is
// idle, even while the previous result still waits in the output register.
// A configuration write clears the integral and the stored error and must be
// issued only while the block is idle.
// ============================================================================
`default_nettype none

module pid_controller_variable_dt_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration
    input  wire logic                                   i_cfg_we,
    input  wire logic [pidvdt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [pidvdt_pkg::DATA_W-1:0]          i_cfg_data,
    // input items
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [pidvdt_pkg::DATA_W-1:0]   i_setpoint,
    input  wire logic signed [pidvdt_pkg::DATA_W-1:0]   i_measured,
    input  wire logic [pidvdt_pkg::DT_W-1:0]            i_elapsed_us,
    // result items
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [pidvdt_pkg::DATA_W-1:0]        o_drive
);

    localparam int unsigned DW   = pidvdt_pkg::DATA_W;
    localparam int unsigned AW   = pidvdt_pkg::ACC_W;
    localparam int unsigned TW   = pidvdt_pkg::DT_W;
    localparam int unsigned MAW  = pidvdt_pkg::MUL_AW;
    localparam int unsigned MBW  = pidvdt_pkg::MUL_BW;
    localparam int unsigned MPW  = pidvdt_pkg::MUL_PW;
    localparam int unsigned DNW  = pidvdt_pkg::DIV_NW;
    localparam int unsigned DDW  = pidvdt_pkg::DIV_DW;
    localparam int unsigned TRW  = pidvdt_pkg::TERM_W;
    localparam int unsigned SW   = pidvdt_pkg::SUM_W;
    localparam int unsigned KW   = pidvdt_pkg::NUMK_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    pidvdt_pkg::t_state r_state;
    pidvdt_pkg::t_state n_state;

    logic signed [DW-1:0] r_prop_gain;
    logic signed [DW-1:0] r_integ_gain;
    logic signed [DW-1:0] r_deriv_gain;
    logic signed [DW-1:0] r_out_upper;
    logic signed [DW-1:0] r_out_lower;
    logic signed [AW-1:0] r_acc;
    logic signed [DW-1:0] r_last;

    logic signed [DW-1:0] r_e;
    logic [TW-1:0]        r_dt;
    logic                 r_eneg;
    logic signed [DW:0]   r_diff;
    logic [KW-1:0]        r_k;
    logic [KW-2:0]        r_nmag;
    logic                 r_nneg;
    logic                 r_msgn;
    logic                 r_mterm;
    logic [TRW-1:0]       r_term;
    logic                 r_term_vld;
    logic signed [SW-1:0] r_sum;
    logic signed [DW-1:0] r_r;
    logic signed [DW-1:0] r_res;
    logic                 r_out_vld;
    logic signed [DW-1:0] r_drive;

    // ------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------
    logic                   mul_start;
    logic [MAW-1:0]         mul_a;
    logic [MBW-1:0]         mul_b;
    logic                   mul_sgn;
    logic                   mul_term;
    logic [MPW-1:0]         mul_prod;
    pidvdt_pkg::t_unit_stat mul_stat;

    logic                   div_start;
    logic [DNW-1:0]         div_num;
    logic [DDW-1:0]         div_den;
    logic [DNW-1:0]         div_quot;
    pidvdt_pkg::t_unit_stat div_stat;

    pidvdt_mul #(
        .AW (MAW),
        .BW (MBW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_stat  (mul_stat)
    );

    pidvdt_div #(
        .NW (DNW),
        .DW (DDW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    // ------------------------------------------------------------------
    // Combinational datapath pieces
    // ------------------------------------------------------------------
    logic                 in_acc;
    logic                 sp_big;
    logic signed [DW-1:0] sp_f;
    logic [DW:0]          err_w;
    logic [DW-1:0]        e_sat;
    logic [DW-1:0]        abs_e;
    logic [AW-1:0]        abs_acc;
    logic [MBW-1:0]       abs_pg;
    logic [MBW-1:0]       abs_ig;
    logic [MBW-1:0]       abs_dg;
    logic [KW-1:0]        diff_x;
    logic [KW-1:0]        k_val;
    logic [KW-1:0]        abs_k;
    logic [AW:0]          q_sgn;
    logic [AW:0]          acc_sum;
    logic [MPW:0]         prod_x;
    logic [MPW:0]         prod_sgn;
    logic                 sum_hi;
    logic                 sum_lo;
    logic                 in_dead;

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        // Drop out-of-range setpoints, then saturate the error to 32 bits
        sp_big = (i_setpoint >= pidvdt_pkg::SP_LIMIT) || (i_setpoint <= -pidvdt_pkg::SP_LIMIT);
        sp_f   = sp_big ? '0 : i_setpoint;
        err_w  = {sp_f[DW-1], sp_f} - {i_measured[DW-1], i_measured};
        if (err_w[DW] != err_w[DW-1]) begin
            e_sat = err_w[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            e_sat = err_w[DW-1:0];
        end

        in_dead = (r_e <= pidvdt_pkg::DEADBAND) && (r_e >= -pidvdt_pkg::DEADBAND);

        // Magnitudes feeding the unsigned serial units
        abs_e   = r_e[DW-1] ? (DW'(0) - r_e) : r_e;
        abs_acc = r_acc[AW-1] ? (AW'(0) - r_acc) : r_acc;
        abs_pg  = r_prop_gain[DW-1]  ? (MBW'(0) - r_prop_gain)  : r_prop_gain;
        abs_ig  = r_integ_gain[DW-1] ? (MBW'(0) - r_integ_gain) : r_integ_gain;
        abs_dg  = r_deriv_gain[DW-1] ? (MBW'(0) - r_deriv_gain) : r_deriv_gain;

        // Error change times 1000 as shifts: 1024 - 32 + 8
        diff_x = {{(KW-DW-1){r_diff[DW]}}, r_diff};
        k_val  = (diff_x << 10) - (diff_x << 5) + (diff_x << 3);
        abs_k  = r_k[KW-1] ? (KW'(0) - r_k) : r_k;

        // Signed integral increment and saturating accumulate
        q_sgn   = r_eneg ? ((AW+1)'(0) - {2'b00, div_quot[AW-2:0]})
                         : {2'b00, div_quot[AW-2:0]};
        acc_sum = {r_acc[AW-1], r_acc} + q_sgn;

        // Apply the product sign; the shift right by 16 is a floor
        prod_x   = {1'b0, mul_prod};
        prod_sgn = r_msgn ? ((MPW+1)'(0) - prod_x) : prod_x;

        // Detect 32-bit overflow of the weighted sum
        sum_hi = !r_sum[SW-1] && (r_sum[SW-2:DW-1] != '0);
        sum_lo =  r_sum[SW-1] && (r_sum[SW-2:DW-1] != '1);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidvdt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = {{(MAW-DW){1'b0}}, abs_e};
        mul_b     = {{(MBW-TW){1'b0}}, r_dt};
        mul_sgn   = 1'b0;
        mul_term  = 1'b0;
        div_start = 1'b0;
        div_num   = mul_prod[DNW-1:0];
        div_den   = pidvdt_pkg::US_PER_MS;
        case (r_state)
            pidvdt_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_elapsed_us == '0) ? pidvdt_pkg::S_EMIT : pidvdt_pkg::S_SETUP;
                end
            end
            pidvdt_pkg::S_SETUP: begin
                // |e| * dt
                mul_start = 1'b1;
                n_state   = pidvdt_pkg::S_MUL1;
            end
            pidvdt_pkg::S_MUL1: begin
                if (mul_stat.done) begin
                    // |e|*dt / 1000 alongside the proportional product
                    div_start = 1'b1;
                    mul_start = 1'b1;
                    mul_b     = abs_pg;
                    mul_sgn   = r_e[DW-1] ^ r_prop_gain[DW-1];
                    mul_term  = 1'b1;
                    n_state   = pidvdt_pkg::S_DIV1;
                end
            end
            pidvdt_pkg::S_DIV1: begin
                if (div_stat.done) begin
                    n_state = pidvdt_pkg::S_ACC;
                end
            end
            pidvdt_pkg::S_ACC: begin
                n_state = pidvdt_pkg::S_LAUNCH2;
            end
            pidvdt_pkg::S_LAUNCH2: begin
                // Derivative quotient alongside the integral product
                div_start = 1'b1;
                div_num   = {{(DNW-KW+1){1'b0}}, r_nmag};
                div_den   = r_dt;
                mul_start = 1'b1;
                mul_a     = abs_acc;
                mul_b     = abs_ig;
                mul_sgn   = r_acc[AW-1] ^ r_integ_gain[DW-1];
                mul_term  = 1'b1;
                n_state   = pidvdt_pkg::S_DIV2;
            end
            pidvdt_pkg::S_DIV2: begin
                if (div_stat.done) begin
                    mul_start = 1'b1;
                    mul_a     = div_quot[MAW-1:0];
                    mul_b     = abs_dg;
                    mul_sgn   = r_nneg ^ r_deriv_gain[DW-1];
                    mul_term  = 1'b1;
                    n_state   = pidvdt_pkg::S_MUL3;
                end
            end
            pidvdt_pkg::S_MUL3: begin
                if (mul_stat.done) begin
                    n_state = pidvdt_pkg::S_SUM;
                end
            end
            pidvdt_pkg::S_SUM: begin
                n_state = pidvdt_pkg::S_SAT;
            end
            pidvdt_pkg::S_SAT: begin
                n_state = pidvdt_pkg::S_CLAMP;
            end
            pidvdt_pkg::S_CLAMP: begin
                n_state = pidvdt_pkg::S_EMIT;
            end
            pidvdt_pkg::S_EMIT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = pidvdt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pidvdt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == pidvdt_pkg::S_IDLE);

    // ------------------------------------------------------------------
    // Configuration and controller state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_out_upper  <= '0;
            r_out_lower  <= '0;
            r_acc        <= '0;
            r_last       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pidvdt_pkg::CFG_PROP:  r_prop_gain  <= i_cfg_data;
                    pidvdt_pkg::CFG_INTEG: r_integ_gain <= i_cfg_data;
                    pidvdt_pkg::CFG_DERIV: r_deriv_gain <= i_cfg_data;
                    pidvdt_pkg::CFG_UPPER: r_out_upper  <= i_cfg_data;
                    pidvdt_pkg::CFG_LOWER: r_out_lower  <= i_cfg_data;
                    default: ;
                endcase
                // Any known register clears the loop state
                if (i_cfg_idx <= pidvdt_pkg::CFG_LOWER) begin
                    r_acc  <= '0;
                    r_last <= '0;
                end
            end
            if (r_state == pidvdt_pkg::S_SETUP) begin
                r_last <= r_e;
                if (in_dead) begin
                    r_acc <= '0;
                end
            end
            // Saturating integral update
            if (r_state == pidvdt_pkg::S_ACC) begin
                if (acc_sum[AW] != acc_sum[AW-1]) begin
                    r_acc <= acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
                end else begin
                    r_acc <= acc_sum[AW-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Control flags of the term path and the output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mterm    <= 1'b0;
            r_term_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (mul_start) begin
                r_mterm <= mul_term;
            end
            r_term_vld <= mul_stat.done && r_mterm;
            if ((r_state == pidvdt_pkg::S_EMIT) && (!r_out_vld || i_out_ready)) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // Capture the item
        if (in_acc) begin
            r_e   <= e_sat;
            r_dt  <= i_elapsed_us;
            r_res <= '0;
        end
        if (r_state == pidvdt_pkg::S_SETUP) begin
            r_eneg <= r_e[DW-1];
            r_diff <= {r_e[DW-1], r_e} - {r_last[DW-1], r_last};
            r_sum  <= '0;
        end
        if (r_state == pidvdt_pkg::S_MUL1) begin
            r_k <= k_val;
        end
        if (r_state == pidvdt_pkg::S_DIV1) begin
            r_nmag <= abs_k[KW-2:0];
            r_nneg <= r_k[KW-1];
        end
        if (mul_start) begin
            r_msgn <= mul_sgn;
        end
        // Hold each signed, floored gain product, then add it in
        if (mul_stat.done && r_mterm) begin
            r_term <= prod_sgn[MPW:16];
        end
        if (r_term_vld) begin
            r_sum <= r_sum + {r_term[TRW-1], r_term};
        end
        if (r_state == pidvdt_pkg::S_SAT) begin
            r_r <= sum_hi ? {1'b0, {(DW-1){1'b1}}} :
                   sum_lo ? {1'b1, {(DW-1){1'b0}}} : r_sum[DW-1:0];
        end
        // Upper bound is tested first
        if (r_state == pidvdt_pkg::S_CLAMP) begin
            r_res <= (r_r > r_out_upper) ? r_out_upper :
                     (r_r < r_out_lower) ? r_out_lower : r_r;
        end
        if ((r_state == pidvdt_pkg::S_EMIT) && (!r_out_vld || i_out_ready)) begin
            r_drive <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive     = r_drive;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pidvdt_pkg::S_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
        else $error("serial unit still running while sequencer idle");

    a_mul_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == pidvdt_pkg::S_DIV1 || r_state == pidvdt_pkg::S_DIV2))
        else $error("divider finished outside a divide wait state");

endmodule

`default_nettype wire

// ===== hdl/pidvdt_mul.sv =====
// ============================================================================
// pidvdt_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ============================================================================
`default_nettype none

module pidvdt_mul #(
    parameter int unsigned AW = 48,
    parameter int unsigned BW = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [AW-1:0]          i_a,
    input  wire logic [BW-1:0]          i_b,
    output logic [AW+BW-1:0]            o_prod,
    output pidvdt_pkg::t_unit_stat      o_stat
);

    localparam int unsigned PW = AW + BW;
    localparam int unsigned CW = $clog2(BW + 1);

    logic [PW-1:0] r_prod;
    logic [AW-1:0] r_a;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [AW:0]   step_sum;

    // Add the multiplicand into the upper half when the current bit is set
    always_comb begin
        step_sum = {1'b0, r_prod[PW-1:BW]} + (r_prod[0] ? {1'b0, r_a} : {(AW+1){1'b0}});
    end

    // Control: count the multiplier bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data: load operands, then shift right one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= {{AW{1'b0}}, i_b};
            r_a    <= i_a;
        end else if (r_busy) begin
            r_prod <= {step_sum, r_prod[BW-1:1]};
        end
    end

    assign o_prod      = r_prod;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ===== hdl/pidvdt_div.sv =====
// ============================================================================
// pidvdt_div
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module pidvdt_div #(
    parameter int unsigned NW = 56,
    parameter int unsigned DW = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [NW-1:0]          i_num,
    input  wire logic [DW-1:0]          i_den,
    output logic [NW-1:0]               o_quot,
    output pidvdt_pkg::t_unit_stat      o_stat
);

    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;
    logic          fits;

    // Bring down the next dividend bit and try the subtraction
    always_comb begin
        trial     = {r_rem, r_q[NW-1]};
        trial_sub = trial - {1'b0, r_den};
        fits      = (trial >= {1'b0, r_den});
    end

    // Control: count the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data: dividend shifts out the top while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], fits};
            r_rem <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ===== bench/pid_controller_variable_dt_core_tb.sv =====
// ============================================================================
// pid_controller_variable_dt_core_tb
// Self-checking bench for the variable-step PID core: a bit-exact predictor
// of the drive output, directed corner items, then randomized register
// settings and items with bursty input traffic and a stalling result side.
// ============================================================================

module pid_controller_variable_dt_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DATA_W        = pidvdt_pkg::DATA_W;
    localparam int     DT_W          = pidvdt_pkg::DT_W;
    localparam int     ACC_W         = pidvdt_pkg::ACC_W;
    localparam int     CFG_IDX_W     = pidvdt_pkg::CFG_IDX_W;
    localparam int     CLK_PERIOD    = 10;
    localparam int     RESET_CYCLES  = 11;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 400;
    localparam int     TIMEOUT_NS    = 20_000_000;
    localparam int     RANDOM_ITEMS  = 700;
    localparam int     NUM_CFG_REGS  = 5;
    localparam int     Q_ONE         = 65536;
    localparam int     FRAC_BITS     = 16;
    localparam int     WIDE_W        = 96;
    localparam longint DATA_MAX      = 64'sd2147483647;
    localparam longint DATA_MIN      = -64'sd2147483648;
    localparam longint ACC_MAX       = 64'sd140737488355327;
    localparam longint ACC_MIN       = -ACC_MAX - 64'sd1;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PULSE
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // Drive predictor and result store
    // ------------------------------------------------------------------------
    class pid_drive_board;
        logic signed [DATA_W-1:0] prop_gain;
        logic signed [DATA_W-1:0] integ_gain;
        logic signed [DATA_W-1:0] deriv_gain;
        logic signed [DATA_W-1:0] out_upper;
        logic signed [DATA_W-1:0] out_lower;
        logic signed [ACC_W-1:0]  integ_sum;
        logic signed [DATA_W-1:0] prev_error;
        logic signed [DATA_W-1:0] pending_drive[$];
        int unsigned              items;
        int unsigned              zero_dt_items;
        int unsigned              results;
        int unsigned              mismatches;

        function new();
            prop_gain     = '0;
            integ_gain    = '0;
            deriv_gain    = '0;
            out_upper     = '0;
            out_lower     = '0;
            integ_sum     = '0;
            prev_error    = '0;
            items         = 0;
            zero_dt_items = 0;
            results       = 0;
            mismatches    = 0;
        endfunction

        // Update a register; any known index also clears the loop state
        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data);
            case (idx)
                pidvdt_pkg::CFG_PROP:  prop_gain  = data;
                pidvdt_pkg::CFG_INTEG: integ_gain = data;
                pidvdt_pkg::CFG_DERIV: deriv_gain = data;
                pidvdt_pkg::CFG_UPPER: out_upper  = data;
                pidvdt_pkg::CFG_LOWER: out_lower  = data;
                default:   return;
            endcase
            integ_sum  = '0;
            prev_error = '0;
        endfunction

        // floor(gain * v / 2^16), exact in a wide signed product
        function logic signed [WIDE_W-1:0] q16_product(input logic signed [DATA_W-1:0] gain,
                                                      input longint v);
            logic signed [WIDE_W-1:0] g;
            logic signed [WIDE_W-1:0] x;
            g = gain;
            x = v;
            return (g * x) >>> FRAC_BITS;
        endfunction

        // Predict the drive for one accepted item and advance the state
        function void note_sample(input logic signed [DATA_W-1:0] sp_in,
                                  input logic signed [DATA_W-1:0] meas,
                                  input logic [DT_W-1:0] dt);
            logic signed [DATA_W-1:0] sp;
            logic signed [DATA_W-1:0] drive;
            longint                   err;
            longint                   dt_l;
            longint                   acc;
            longint                   der;
            logic signed [WIDE_W-1:0] total;
            items++;
            // zero elapsed time: drive zero, state kept
            if (dt == '0) begin
                zero_dt_items++;
                pending_drive.push_back('0);
                return;
            end
            sp = sp_in;
            if (sp >= pidvdt_pkg::SP_LIMIT || sp <= -pidvdt_pkg::SP_LIMIT) sp = '0;
            err = longint'(sp) - longint'(meas);
            if (err > DATA_MAX) err = DATA_MAX;
            else if (err < DATA_MIN) err = DATA_MIN;
            // small error drops the integral before it accumulates
            if (err <= longint'(pidvdt_pkg::DEADBAND) && err >= -longint'(pidvdt_pkg::DEADBAND))
                integ_sum = '0;
            dt_l = longint'(dt);
            acc  = longint'(integ_sum) + (err * dt_l) / longint'(pidvdt_pkg::US_PER_MS);
            if (acc > ACC_MAX) acc = ACC_MAX;
            else if (acc < ACC_MIN) acc = ACC_MIN;
            integ_sum = acc[ACC_W-1:0];
            der   = ((err - longint'(prev_error)) * longint'(pidvdt_pkg::US_PER_MS)) / dt_l;
            total = q16_product(prop_gain, err) + q16_product(integ_gain, acc)
                  + q16_product(deriv_gain, der);
            if (total > DATA_MAX) total = DATA_MAX;
            else if (total < DATA_MIN) total = DATA_MIN;
            drive = total[DATA_W-1:0];
            // upper bound wins when the bounds are inverted
            if (drive > out_upper) drive = out_upper;
            else if (drive < out_lower) drive = out_lower;
            prev_error = err[DATA_W-1:0];
            pending_drive.push_back(drive);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_drive(input logic signed [DATA_W-1:0] actual);
            logic signed [DATA_W-1:0] want;
            results++;
            if (pending_drive.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected drive, expected none, actual %0d",
                         $time, actual);
                return;
            end
            want = pending_drive.pop_front();
            if (actual !== want) begin
                mismatches++;
                $display("%0t: drive mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                         $time, want, want, actual, actual);
            end
        endfunction

        function int pending();
            return pending_drive.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals
    // ------------------------------------------------------------------------
    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx    = '0;
    logic [DATA_W-1:0]           i_cfg_data   = '0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_ready;
    logic signed [DATA_W-1:0]    i_setpoint   = '0;
    logic signed [DATA_W-1:0]    i_measured   = '0;
    logic [DT_W-1:0]             i_elapsed_us = '0;
    logic                        o_out_valid;
    logic                        i_out_ready  = 1'b0;
    logic signed [DATA_W-1:0]    o_drive;

    pid_drive_board board;
    int             burst_left   = 0;
    int             reg_settings = 0;
    t_rx_mode       rx_mode      = RX_OPEN;
    int             rx_left      = 0;
    logic [2:0]     rx_tick      = '0;

    pid_controller_variable_dt_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_setpoint   (i_setpoint),
        .i_measured   (i_measured),
        .i_elapsed_us (i_elapsed_us),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_drive      (o_drive)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #TIMEOUT_NS;
        $display("Timeout with %0d drive results outstanding", board.pending());
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted item, stall in changing patterns
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_drive(o_drive);
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 256);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 7) == 0);
            default:   i_out_ready <= (rx_tick < 3'd5);
        endcase
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one item, hold it until accepted, then idle between bursts
    task automatic send_item(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] meas,
                             input logic [DT_W-1:0] dt);
        int gap;
        i_in_valid   <= 1'b1;
        i_setpoint   <= sp;
        i_measured   <= meas;
        i_elapsed_us <= dt;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(sp, meas, dt);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 260) : $urandom_range(1, 20);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every predicted drive has come back
    task automatic settle_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; the caller lowers the write enable afterwards
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Load a full register setting while the block is idle
    task automatic program_regs(input logic [DATA_W-1:0] prop, input logic [DATA_W-1:0] integ,
                                input logic [DATA_W-1:0] deriv, input logic [DATA_W-1:0] upper,
                                input logic [DATA_W-1:0] lower);
        settle_results();
        cfg_write(pidvdt_pkg::CFG_PROP, prop);
        cfg_write(pidvdt_pkg::CFG_INTEG, integ);
        cfg_write(pidvdt_pkg::CFG_DERIV, deriv);
        cfg_write(pidvdt_pkg::CFG_UPPER, upper);
        cfg_write(pidvdt_pkg::CFG_LOWER, lower);
        i_cfg_we <= 1'b0;
        reg_settings++;
    endtask

    // Write an index past the register list; state must survive it
    task automatic poke_spare_index();
        settle_results();
        cfg_write(CFG_IDX_W'(NUM_CFG_REGS + $urandom_range(0, 2)), $urandom());
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_setpoint();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: begin
                // right around the setpoint cutoff
                v = pidvdt_pkg::SP_LIMIT + $urandom_range(0, 4) - 2;
                return $urandom_range(0, 1) ? v : -v;
            end
            default: return $urandom_range(0, 2 * 655359) - 655359;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_elapsed();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 24'hFF_FFFF;
            2:       return 24'd1;
            3:       return DT_W'($urandom());
            4, 5:    return DT_W'($urandom_range(1, 100000));
            default: return DT_W'($urandom_range(1, 5000));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [DATA_W-1:0] sp;
        logic [DATA_W-1:0] meas;
        logic [DATA_W-1:0] upper;
        logic [DATA_W-1:0] lower;
        int                phase_len;
        int                random_sent;

        board       = new();
        random_sent = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All registers zero after reset: drive pinned at zero
        send_item(32'h0001_0000, 32'hFFFF_0000, 24'd1000);

        // Moderate gains, wide clamp
        program_regs(Q_ONE, Q_ONE / 2, 655, 1000 * Q_ONE, -(1000 * Q_ONE));
        send_item(32'h0000_4000, '0, '0);
        send_item(pidvdt_pkg::SP_LIMIT, '0, 24'd1000);
        send_item(pidvdt_pkg::SP_LIMIT - 1, '0, 24'd1000);
        send_item(-pidvdt_pkg::SP_LIMIT, '0, 24'd1000);
        send_item(-pidvdt_pkg::SP_LIMIT + 1, '0, 24'd1000);
        send_item(pidvdt_pkg::DEADBAND, '0, 24'd500);
        send_item(pidvdt_pkg::DEADBAND + 1, '0, 24'd500);
        send_item(-pidvdt_pkg::DEADBAND, '0, 24'd500);
        send_item(-pidvdt_pkg::DEADBAND - 1, '0, 24'd500);
        send_item(pidvdt_pkg::SP_LIMIT - 1, 32'h8000_0000, 24'd1);
        send_item(-pidvdt_pkg::SP_LIMIT + 1, 32'h7FFF_FFFF, 24'hFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 24'd1000);
        send_item(32'h8000_0000, 32'h0003_0000, 24'd1000);
        // zero elapsed time must keep the state
        send_item(32'h0002_0000, 32'hFFF0_0000, '0);
        poke_spare_index();
        send_item(32'h0001_8000, '0, 24'd250);

        // Extreme gains, full clamp: drive the integral into saturation both ways
        program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        repeat (5) send_item('0, 32'h8000_0000, 24'hFF_FFFF);
        send_item('0, '0, 24'd1);
        repeat (5) send_item('0, 32'h7FFF_FFFF, 24'hFF_FFFF);

        // Inverted clamp bounds
        program_regs(3 * Q_ONE, '0, '0, -(5 * Q_ONE), 5 * Q_ONE);
        send_item(32'h0004_0000, '0, 24'd1000);
        send_item('0, 32'h0004_0000, 24'd1000);

        // Random register settings, each followed by a run of random items
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: begin
                    upper = 32'h7FFF_FFFF;
                    lower = 32'h8000_0000;
                end
                1: begin
                    upper = $urandom_range(1, 50 * Q_ONE);
                    lower = -$urandom_range(1, 50 * Q_ONE);
                end
                2: begin
                    upper = -$urandom_range(0, 5 * Q_ONE);
                    lower = $urandom_range(0, 5 * Q_ONE);
                end
                default: begin
                    upper = $urandom();
                    lower = $urandom();
                end
            endcase
            program_regs(pick_gain(), pick_gain(), pick_gain(), upper, lower);
            phase_len = $urandom_range(50, 130);
            if (phase_len > RANDOM_ITEMS - random_sent) phase_len = RANDOM_ITEMS - random_sent;
            repeat (phase_len) begin
                sp = pick_setpoint();
                case ($urandom_range(0, 5))
                    0, 1:    meas = sp + $urandom_range(0, 16000) - 8000;
                    2:       meas = $urandom();
                    default: meas = $urandom_range(0, 24 * Q_ONE) - 12 * Q_ONE;
                endcase
                send_item(sp, meas, pick_elapsed());
                random_sent++;
                case ($urandom_range(0, 99))
                    0:       settle_results();
                    1:       poke_spare_index();
                    default: ;
                endcase
            end
        end

        // Drain and watch for stray results
        settle_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d items (%0d with zero elapsed time) under %0d register settings",
                 board.items, board.zero_dt_items, reg_settings + 1);
        $display("Compared %0d drive results, %0d wrong, %0d never arrived",
                 board.results, board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
